// ===== hdl/ksb_pkg.sv =====
// Shared constants, types and helpers of the keyed sprite blitter.
package ksb_pkg;

   localparam int MAX_WIDTH   = 8;
   localparam int MAX_HEIGHT  = 8;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int IDXC_W = IDX_W + 1;
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DIMW_W = $clog2(MAX_WIDTH + 1);
   localparam int DIMH_W = $clog2(MAX_HEIGHT + 1);

   localparam int CFG_DIM_W = 4;
   localparam int COLOR_W   = 32;
   localparam int COORD_W   = 12;
   localparam int DEST_W    = 13;
   localparam int SIDE_W    = 4;
   localparam int PIX_IDX_W = 6;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_MIRROR = 2'd1,
      OP_SCALE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_KEY    = 2'd2,
      REG_NONE   = 2'd3
   } csr_reg_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DRAW = 1'b1
   } cmd_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DRAW = 1'b1
   } state_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [IDX_W-1:0]           index;
      logic [COLOR_W-1:0]         color;
      logic [COORD_W-1:0]         origin_x;
      logic [COORD_W-1:0]         origin_y;
      logic                       mirror_x;
      logic                       mirror_y;
      logic [SIDE_W-1:0]          side;
   } cmd_type;

   typedef struct packed {
      logic [DEST_W-1:0]          dest_x;
      logic [DEST_W-1:0]          dest_y;
      logic [COLOR_W-1:0]         color;
      logic [SIDE_W-1:0]          side;
      logic                       write_enable;
      logic                       last;
   } rsp_type;

   function automatic logic [DIMW_W-1:0] clamp_width(input logic [CFG_DIM_W-1:0] v);
      if (int'(v) > MAX_WIDTH) return DIMW_W'(MAX_WIDTH);
      else return DIMW_W'(v);
   endfunction

   function automatic logic [DIMH_W-1:0] clamp_height(input logic [CFG_DIM_W-1:0] v);
      if (int'(v) > MAX_HEIGHT) return DIMH_W'(MAX_HEIGHT);
      else return DIMH_W'(v);
   endfunction

endpackage

// ===== hdl/ksb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module ksb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic                              rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/ksb_front.sv =====
// Front end: accepts request items, decodes them and queues commands.
module ksb_front import ksb_pkg::*; (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic [DIMW_W-1:0]     width,
   input  logic [DIMH_W-1:0]     height,
   input  logic                  queue_full,
   output logic                  push,
   output cmd_type               push_cmd
);

   op_type                 op;
   logic [PIX_IDX_W-1:0]   pixel_index;
   logic [SIDE_W-1:0]      scale;
   logic                   keep;
   logic                   dims_ok;

   always_comb begin
      op          = op_type'(req_tuser);
      pixel_index = req_tdata[5:0];
      scale       = req_tdata[67:64];
      dims_ok     = (width != '0) && (height != '0);

      case (op)
         OP_LOAD:   keep = int'(pixel_index) < STORE_DEPTH;
         OP_MIRROR: keep = dims_ok;
         OP_SCALE:  keep = dims_ok && (scale != '0);
         default:   keep = 1'b0;
      endcase

      push_cmd.kind     = (op == OP_LOAD) ? CMD_LOAD : CMD_DRAW;
      push_cmd.index    = IDX_W'(pixel_index);
      push_cmd.color    = req_tdata[37:6];
      push_cmd.origin_x = req_tdata[49:38];
      push_cmd.origin_y = req_tdata[61:50];
      push_cmd.mirror_x = req_tdata[62] && (op == OP_MIRROR);
      push_cmd.mirror_y = req_tdata[63] && (op == OP_MIRROR);
      push_cmd.side     = (op == OP_MIRROR) ? SIDE_W'(1) : scale;

      req_tready = !queue_full;
      push       = req_tvalid && !queue_full && keep;
   end

endmodule

// ===== hdl/ksb_cmd_queue.sv =====
// Two-entry command queue between the decoder and the draw engine.
module ksb_cmd_queue import ksb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    not_empty,
   output logic    full
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      head      = entry_ff[rd_ptr_ff];
      not_empty = count_ff != 2'd0;
      full      = count_ff == 2'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/ksb_back.sv =====
// Back end: executes loads and walks draws over the sprite store.
module ksb_back import ksb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic                  cmd_valid,
   output logic                  cmd_pop,
   input  logic [DIMW_W-1:0]     width,
   input  logic [DIMH_W-1:0]     height,
   input  logic [COLOR_W-1:0]    color_key,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   state_type          state_ff, state_in;
   cmd_type            draw_ff, draw_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;

   // read-stage metadata, lines up with the RAM output
   logic               p_valid_ff;
   logic [DEST_W-1:0]  p_dx_ff, p_dy_ff;
   logic [SIDE_W-1:0]  p_side_ff;
   logic               p_last_ff;

   rsp_type            fifo_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         occ_ff;

   logic               ram_we;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [COLOR_W-1:0] rd_data;

   logic               col_end, row_end;
   logic [DIMH_W-1:0]  srow;
   logic [DIMW_W-1:0]  scol;
   logic [DEST_W-1:0]  dx, dy;
   logic [1:0]         used;
   logic               pop;
   logic               room;
   rsp_type            head;

   ksb_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cmd.index),
      .wr_data (cmd.color),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      col_end = DIMW_W'(col_ff) == (width - DIMW_W'(1));
      row_end = DIMH_W'(row_ff) == (height - DIMH_W'(1));
      srow = draw_ff.mirror_y ? (height - DIMH_W'(1) - DIMH_W'(row_ff)) : DIMH_W'(row_ff);
      scol = draw_ff.mirror_x ? (width - DIMW_W'(1) - DIMW_W'(col_ff)) : DIMW_W'(col_ff);
      rd_addr = IDX_W'(IDXC_W'(srow) * IDXC_W'(width) + IDXC_W'(scol));
      dx = {draw_ff.origin_x[COORD_W-1], draw_ff.origin_x}
           + DEST_W'(col_ff) * DEST_W'(draw_ff.side);
      dy = {draw_ff.origin_y[COORD_W-1], draw_ff.origin_y}
           + DEST_W'(row_ff) * DEST_W'(draw_ff.side);

      head       = fifo_ff[rd_ptr_ff];
      rsp_tvalid = occ_ff != 2'd0;
      rsp_tdata  = {1'b0, head.write_enable, head.side, head.color, head.dest_y, head.dest_x};
      rsp_tlast  = head.last;
      pop        = rsp_tvalid && rsp_tready;
      // one slot per read in flight, so the output queue never overflows
      used       = occ_ff + {1'b0, p_valid_ff};
      room       = (used < 2'd2) || pop;

      state_in = state_ff;
      draw_in  = draw_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      cmd_pop  = 1'b0;
      ram_we   = 1'b0;
      rd_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind == CMD_LOAD) begin
                  ram_we = 1'b1;
               end else begin
                  draw_in  = cmd;
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_DRAW;
               end
            end
         end
         ST_DRAW: begin
            if (room) begin
               rd_en = 1'b1;
               if (col_end) begin
                  col_in = '0;
                  if (row_end) begin
                     state_in = ST_IDLE;
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_ff     <= '0;
         col_ff     <= '0;
         p_valid_ff <= 1'b0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         occ_ff     <= 2'd0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         p_valid_ff <= rd_en;
         if (p_valid_ff) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         occ_ff <= occ_ff + {1'b0, p_valid_ff} - {1'b0, pop};
      end
      draw_ff <= draw_in;
      if (rd_en) begin
         p_dx_ff   <= dx;
         p_dy_ff   <= dy;
         p_side_ff <= draw_ff.side;
         p_last_ff <= col_end && row_end;
      end
      if (p_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= '{dest_x: p_dx_ff, dest_y: p_dy_ff, color: rd_data,
                                 side: p_side_ff, write_enable: rd_data != color_key,
                                 last: p_last_ff};
      end
   end

endmodule

// ===== hdl/keyed_sprite_blitter_top.sv =====
// Top level of the colour-keyed sprite blitter with its register port.
// A load item is written to the 64-entry sprite store at the edge at which it leaves the
// command queue. A draw item walks the sprite in row-major destination order and gives
// one result per stored pixel, width times height results, at one result per cycle
// while rsp_tready stays high; the single read port of the sprite store sets that pace.
// A two-entry command queue lets request items be taken while a draw is under way;
// mirrored draws give single pixels, scaled draws squares.
// Registers: 0x0 sprite_width, 0x4 sprite_height, 0x8 color_key.
module keyed_sprite_blitter_top import ksb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pixel_index[5:0], pixel_color[37:6], origin_x[49:38], origin_y[61:50],
   // mirror_x[62], mirror_y[63], scale_factor[67:64]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // dest_x[12:0], dest_y[25:13], out_color[57:26], square_side[61:58],
   // write_enable[62]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic [COLOR_W-1:0]   key_ff, key_in;
   csr_reg_type          csr_sel;
   logic                 csr_wr;
   logic [DIMW_W-1:0]    width;
   logic [DIMH_W-1:0]    height;

   logic                 push;
   cmd_type              push_cmd;
   logic                 pop;
   cmd_type              head;
   logic                 not_empty;
   logic                 full;

   always_comb begin
      csr_pready = 1'b1;
      csr_sel    = csr_reg_type'(csr_paddr[3:2]);
      csr_wr     = csr_psel && csr_penable && csr_pwrite;
      width_in   = width_ff;
      height_in  = height_ff;
      key_in     = key_ff;
      csr_prdata = '0;
      case (csr_sel)
         REG_WIDTH: begin
            csr_prdata = 32'(width_ff);
            if (csr_wr) width_in = csr_pwdata[CFG_DIM_W-1:0];
         end
         REG_HEIGHT: begin
            csr_prdata = 32'(height_ff);
            if (csr_wr) height_in = csr_pwdata[CFG_DIM_W-1:0];
         end
         REG_KEY: begin
            csr_prdata = key_ff;
            if (csr_wr) key_in = csr_pwdata;
         end
         default: csr_prdata = '0;
      endcase
      width  = clamp_width(width_ff);
      height = clamp_height(height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_W'(8);
         height_ff <= CFG_DIM_W'(8);
         key_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         key_ff    <= key_in;
      end
   end

   ksb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .width      (width),
      .height     (height),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ksb_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   ksb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (head),
      .cmd_valid  (not_empty),
      .cmd_pop    (pop),
      .width      (width),
      .height     (height),
      .color_key  (key_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
